// File: rtl/ring_resource_token_arbiter_core_assert.svh
// ----------------------------------------------------------------------------
// Ring resource token arbiter assertion macros
// Clocked property macros used by the arbiter core RTL.
// ----------------------------------------------------------------------------
`ifndef RING_RESOURCE_TOKEN_ARBITER_CORE_ASSERT_SVH
`define RING_RESOURCE_TOKEN_ARBITER_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define RRTA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define RRTA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/rrta_pkg.sv
// ----------------------------------------------------------------------------
// rrta_pkg
// Types, codes and ring helpers for the ring resource token arbiter.
// ----------------------------------------------------------------------------
package rrta_pkg;

  localparam int SEAT_W = 4;
  localparam int MASK_W = 5;

  localparam logic CMD_REQ = 1'b0;
  localparam logic CMD_REL = 1'b1;

  localparam logic TOK_LEFT  = 1'b0;
  localparam logic TOK_RIGHT = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_GRANT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [MASK_W-1:0] newly_granted;
    logic [MASK_W-1:0] granted_mask;
    logic [MASK_W-1:0] waiting_mask;
    logic              bad_event;
  } result_t;

  function automatic int ring_left(int j, int n);
    return (j == 0) ? n - 1 : j - 1;
  endfunction

  function automatic int ring_right(int j, int n);
    return (j == n - 1) ? 0 : j + 1;
  endfunction

endpackage

// File: rtl/rrta_in_stage.sv
// ----------------------------------------------------------------------------
// rrta_in_stage
// Input register: holds one command transaction until the evaluator takes it.
// ----------------------------------------------------------------------------
module rrta_in_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic [rrta_pkg::SEAT_W-1:0] seat,
  input  logic                        take,
  output logic                        q_valid,
  output logic                        q_cmd,
  output logic [rrta_pkg::SEAT_W-1:0] q_seat
);
  import rrta_pkg::*;

  logic accept;

  assign in_ready = !q_valid || take;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (accept) begin
      q_valid <= 1'b1;
    end else if (take) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_cmd  <= cmd;
      q_seat <= seat;
    end
  end

endmodule

// File: rtl/rrta_step.sv
// ----------------------------------------------------------------------------
// rrta_step
// Single-pass evaluation of one request or release against the ring state.
// ----------------------------------------------------------------------------
module rrta_step #(
  parameter int SEATS = 5
) (
  input  logic                          cmd,
  input  logic [rrta_pkg::SEAT_W-1:0]   seat,
  input  rrta_pkg::phase_t [SEATS-1:0]  phase,
  input  logic [SEATS-1:0]              owner,
  output rrta_pkg::phase_t [SEATS-1:0]  phase_next,
  output logic [SEATS-1:0]              owner_next,
  output rrta_pkg::result_t             res
);
  import rrta_pkg::*;

  localparam int PAD_W = (SEATS > MASK_W) ? SEATS : MASK_W;

  logic [SEATS-1:0] sel;
  logic [SEATS-1:0] is_left;
  logic [SEATS-1:0] is_right;
  logic [SEATS-1:0] idle_v;
  logic [SEATS-1:0] grant_v;
  logic             in_range;
  logic             is_req;
  logic             bad;
  logic             ok;

  phase_t [SEATS-1:0] phase1;
  phase_t [SEATS-1:0] phase2;
  logic [SEATS-1:0]   owner1;
  logic [SEATS-1:0]   grant_a;
  logic [SEATS-1:0]   grant_b;
  logic [SEATS-1:0]   fresh;
  logic [SEATS-1:0]   gmask;
  logic [SEATS-1:0]   wmask;
  logic [PAD_W-1:0]   fresh_pad;
  logic [PAD_W-1:0]   gmask_pad;
  logic [PAD_W-1:0]   wmask_pad;

  always_comb begin
    for (int j = 0; j < SEATS; j++) begin
      sel[j]     = (seat == SEAT_W'(j));
      idle_v[j]  = (phase[j] == PH_IDLE);
      grant_v[j] = (phase[j] == PH_GRANT);
    end
    for (int j = 0; j < SEATS; j++) begin
      is_left[j]  = sel[ring_right(j, SEATS)];
      is_right[j] = sel[ring_left(j, SEATS)];
    end
  end

  assign in_range = ({1'b0, seat} < (SEAT_W + 1)'(SEATS));
  assign is_req   = (cmd == CMD_REQ);
  assign bad      = !in_range || (is_req ? ~|(sel & idle_v) : ~|(sel & grant_v));
  assign ok       = !bad;

  always_comb begin
    for (int j = 0; j < SEATS; j++) begin
      phase1[j] = phase[j];
      owner1[j] = owner[j];
      if (ok && is_req && sel[j]) begin
        phase1[j] = PH_WAIT;
      end
      if (ok && !is_req && sel[j]) begin
        phase1[j] = PH_IDLE;
        owner1[j] = TOK_RIGHT;
      end
      if (ok && !is_req && is_left[j]) begin
        owner1[j] = TOK_LEFT;
      end
    end
    for (int j = 0; j < SEATS; j++) begin
      grant_a[j] = ok && ((is_req && sel[j]) || (!is_req && is_left[j])) &&
                   (phase1[j] == PH_WAIT) &&
                   (phase1[ring_left(j, SEATS)] != PH_GRANT) &&
                   (phase1[ring_right(j, SEATS)] != PH_GRANT) &&
                   (owner1[j] == TOK_LEFT) &&
                   (owner1[ring_left(j, SEATS)] == TOK_RIGHT);
    end
    for (int j = 0; j < SEATS; j++) begin
      phase2[j] = grant_a[j] ? PH_GRANT : phase1[j];
    end
    for (int j = 0; j < SEATS; j++) begin
      grant_b[j] = ok && !is_req && is_right[j] &&
                   (phase2[j] == PH_WAIT) &&
                   (phase2[ring_left(j, SEATS)] != PH_GRANT) &&
                   (phase2[ring_right(j, SEATS)] != PH_GRANT) &&
                   (owner1[j] == TOK_LEFT) &&
                   (owner1[ring_left(j, SEATS)] == TOK_RIGHT);
    end
    for (int j = 0; j < SEATS; j++) begin
      phase_next[j] = grant_b[j] ? PH_GRANT : phase2[j];
      gmask[j]      = (phase_next[j] == PH_GRANT);
      wmask[j]      = (phase_next[j] == PH_WAIT);
    end
  end

  assign owner_next = owner1;
  assign fresh      = grant_a | grant_b;
  assign fresh_pad  = PAD_W'(fresh);
  assign gmask_pad  = PAD_W'(gmask);
  assign wmask_pad  = PAD_W'(wmask);

  assign res.newly_granted = fresh_pad[MASK_W-1:0];
  assign res.granted_mask  = gmask_pad[MASK_W-1:0];
  assign res.waiting_mask  = wmask_pad[MASK_W-1:0];
  assign res.bad_event     = bad;

endmodule

// File: rtl/ring_resource_token_arbiter_core.sv
// ----------------------------------------------------------------------------
// ring_resource_token_arbiter_core: token arbiter for a ring of seats
// Input reg, then result reg; the seat phase and token update is one pass.
// Throughput: one transaction per cycle unless out_ready stalls the result reg.
// Reset: all seats idle, tokens to the right seat for odd resources below the last.
// ----------------------------------------------------------------------------
`include "ring_resource_token_arbiter_core_assert.svh"

module ring_resource_token_arbiter_core #(
  parameter int SEATS = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic [rrta_pkg::SEAT_W-1:0] seat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rrta_pkg::MASK_W-1:0] newly_granted,
  output logic [rrta_pkg::MASK_W-1:0] granted_mask,
  output logic [rrta_pkg::MASK_W-1:0] waiting_mask,
  output logic                        bad_event
);
  import rrta_pkg::*;

  logic               q_valid;
  logic               q_cmd;
  logic [SEAT_W-1:0]  q_seat;
  logic               take;
  phase_t [SEATS-1:0] phase;
  phase_t [SEATS-1:0] phase_next;
  logic [SEATS-1:0]   owner;
  logic [SEATS-1:0]   owner_next;
  result_t            res_next;
  result_t            res;
  logic [SEATS-1:0]   gvec;
  logic [SEATS-1:0]   gvec_rot;

  assign take = q_valid && (!out_valid || out_ready);

  rrta_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .seat     (seat),
    .take     (take),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_seat   (q_seat)
  );

  rrta_step #(
    .SEATS (SEATS)
  ) u_step (
    .cmd        (q_cmd),
    .seat       (q_seat),
    .phase      (phase),
    .owner      (owner),
    .phase_next (phase_next),
    .owner_next (owner_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SEATS; k++) begin
        phase[k] <= PH_IDLE;
        owner[k] <= (k[0] && (k < SEATS - 1)) ? TOK_RIGHT : TOK_LEFT;
      end
      out_valid <= 1'b0;
    end else if (take) begin
      phase     <= phase_next;
      owner     <= owner_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign newly_granted = res.newly_granted;
  assign granted_mask  = res.granted_mask;
  assign waiting_mask  = res.waiting_mask;
  assign bad_event     = res.bad_event;

  always_comb begin
    for (int k = 0; k < SEATS; k++) begin
      gvec[k] = (phase[k] == PH_GRANT);
    end
  end

  assign gvec_rot = {gvec[SEATS-2:0], gvec[SEATS-1]};

  `RRTA_ASSERT_ALWAYS(a_no_adjacent_grant, (gvec & gvec_rot) == '0, "neighbors both granted")
  `RRTA_ASSERT_IMPLIES(a_grant_wait_disjoint, out_valid, (granted_mask & waiting_mask) == '0, "seat both granted and waiting")
  `RRTA_ASSERT_IMPLIES(a_fresh_is_granted, out_valid, (newly_granted & ~granted_mask) == '0, "new grant missing from grant mask")
  `RRTA_ASSERT_IMPLIES(a_bad_no_grant, out_valid && bad_event, newly_granted == '0, "ignored transaction granted a seat")

endmodule

// File: tb/ring_resource_token_arbiter_core_tb.sv
// ----------------------------------------------------------------------------
// ring_resource_token_arbiter_core_tb
// Self-checking bench for the ring token arbiter. A clocked driver feeds
// request and release transactions from a queue, a clocked monitor checks
// every result against a cycle-free model of seat phases and tokens.
// ----------------------------------------------------------------------------
module ring_resource_token_arbiter_core_tb;
  import rrta_pkg::*;

  localparam int SEATS = 5;
  localparam int LIMIT_TIME = 2_000_000;

  typedef struct packed {
    phase_t [SEATS-1:0] ph;
    logic   [SEATS-1:0] tok;
  } ring_t;

  typedef struct packed {
    logic              c;
    logic [SEAT_W-1:0] s;
  } arb_cmd_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              cmd = CMD_REQ;
  logic [SEAT_W-1:0] seat = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [MASK_W-1:0] newly_granted;
  logic [MASK_W-1:0] granted_mask;
  logic [MASK_W-1:0] waiting_mask;
  logic              bad_event;

  arb_cmd_t pending_q[$];
  result_t  expected_q[$];
  ring_t    model;
  ring_t    gen;
  arb_cmd_t drv_item;
  result_t  want;
  logic     in_taken = 1'b0;
  int       sent_cnt = 0;
  int       taken_cnt = 0;
  int       got_cnt = 0;
  int       fail_cnt = 0;
  int       flagged_cnt = 0;
  int       grant_cnt = 0;
  int       hold_left = 0;
  logic     held = 1'b0;

  ring_resource_token_arbiter_core #(
    .SEATS(SEATS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .seat         (seat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .newly_granted(newly_granted),
    .granted_mask (granted_mask),
    .waiting_mask (waiting_mask),
    .bad_event    (bad_event)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic ring_t ring_reset();
    ring_t st;
    for (int k = 0; k < SEATS; k++) begin
      st.ph[k]  = PH_IDLE;
      st.tok[k] = ((k % 2) == 1 && k + 1 < SEATS) ? TOK_RIGHT : TOK_LEFT;
    end
    return st;
  endfunction

  function automatic logic seat_claim(inout ring_t st, input int s);
    int l;
    int r;
    l = (s + SEATS - 1) % SEATS;
    r = (s + 1) % SEATS;
    if (st.ph[s] == PH_WAIT && st.ph[l] != PH_GRANT && st.ph[r] != PH_GRANT &&
        st.tok[s] == TOK_LEFT && st.tok[l] == TOK_RIGHT) begin
      st.ph[s] = PH_GRANT;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t arb_step(inout ring_t st, input logic c,
                                       input logic [SEAT_W-1:0] s);
    result_t    res;
    logic [15:0] fresh;
    int          si;
    int          l;
    int          r;
    res   = '0;
    fresh = '0;
    si    = int'(s);
    if (si >= SEATS) begin
      res.bad_event = 1'b1;
    end else if (c == CMD_REQ) begin
      if (st.ph[si] != PH_IDLE) begin
        res.bad_event = 1'b1;
      end else begin
        st.ph[si] = PH_WAIT;
        if (seat_claim(st, si)) fresh[si] = 1'b1;
      end
    end else begin
      if (st.ph[si] != PH_GRANT) begin
        res.bad_event = 1'b1;
      end else begin
        l = (si + SEATS - 1) % SEATS;
        r = (si + 1) % SEATS;
        st.ph[si]  = PH_IDLE;
        st.tok[si] = TOK_RIGHT;
        st.tok[l]  = TOK_LEFT;
        if (seat_claim(st, l)) fresh[l] = 1'b1;
        if (seat_claim(st, r)) fresh[r] = 1'b1;
      end
    end
    res.newly_granted = fresh[MASK_W-1:0];
    for (int k = 0; k < SEATS && k < MASK_W; k++) begin
      res.granted_mask[k] = (st.ph[k] == PH_GRANT);
      res.waiting_mask[k] = (st.ph[k] == PH_WAIT);
    end
    return res;
  endfunction

  function automatic void enqueue_cmd(logic c, logic [SEAT_W-1:0] s);
    arb_cmd_t it;
    result_t  unused;
    it.c = c;
    it.s = s;
    pending_q.push_back(it);
    unused = arb_step(gen, c, s);
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_q.size() != 0 &&
          ((sent_cnt >= 400 && sent_cnt < 600) || $urandom_range(0, 99) >= 10)) begin
        drv_item = pending_q.pop_front();
        in_valid <= 1'b1;
        cmd      <= drv_item.c;
        seat     <= drv_item.s;
        sent_cnt++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held && got_cnt >= 200) begin
      held      <= 1'b1;
      hold_left <= 80;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (got_cnt >= 400 && got_cnt < 600) || $urandom_range(0, 99) >= 10;
    end
  end

  // monitor
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      expected_q.push_back(arb_step(model, cmd, seat));
      taken_cnt++;
    end
    if (!rst && out_valid && out_ready) begin
      got_cnt++;
      if (expected_q.size() == 0) begin
        $error("result transaction with no expectation pending");
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (newly_granted !== want.newly_granted) begin
          $error("newly_granted: expected %0h, got %0h", want.newly_granted, newly_granted);
          fail_cnt++;
        end
        if (granted_mask !== want.granted_mask) begin
          $error("granted_mask: expected %0h, got %0h", want.granted_mask, granted_mask);
          fail_cnt++;
        end
        if (waiting_mask !== want.waiting_mask) begin
          $error("waiting_mask: expected %0h, got %0h", want.waiting_mask, waiting_mask);
          fail_cnt++;
        end
        if (bad_event !== want.bad_event) begin
          $error("bad_event: expected %0h, got %0h", want.bad_event, bad_event);
          fail_cnt++;
        end
        flagged_cnt += want.bad_event;
        grant_cnt   += $countones(want.newly_granted);
      end
    end
  end

  initial begin
    int good_cnt;
    int tries;
    int pick;
    int cand[$];
    good_cnt = 0;
    tries    = 0;
    model    = ring_reset();
    gen      = ring_reset();

    for (int k = 0; k < SEATS; k++) enqueue_cmd(CMD_REQ, k[SEAT_W-1:0]);
    enqueue_cmd(CMD_REQ, 4'd5);
    enqueue_cmd(CMD_REL, 4'd15);
    enqueue_cmd(CMD_REQ, 4'd15);
    enqueue_cmd(CMD_REL, 4'd10);
    enqueue_cmd(CMD_REQ, 4'd2);
    for (int k = 0; k < SEATS; k++) enqueue_cmd(CMD_REL, k[SEAT_W-1:0]);
    for (int k = 0; k < SEATS; k++) enqueue_cmd(CMD_REQ, k[SEAT_W-1:0]);
    for (int k = SEATS - 1; k >= 0; k--) enqueue_cmd(CMD_REL, k[SEAT_W-1:0]);

    while (good_cnt < 900 && tries < 4000) begin
      tries++;
      if ($urandom_range(0, 99) < 12) begin
        enqueue_cmd(1'($urandom_range(0, 1)), SEAT_W'($urandom_range(0, 15)));
      end else begin
        cand.delete();
        for (int k = 0; k < SEATS; k++) begin
          if (gen.ph[k] != PH_WAIT) cand.push_back(k);
        end
        if (cand.size() != 0) begin
          pick = cand[$urandom_range(0, cand.size() - 1)];
          enqueue_cmd((gen.ph[pick] == PH_GRANT) ? CMD_REL : CMD_REQ, pick[SEAT_W-1:0]);
          good_cnt++;
        end
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d results from %0d transactions over %0d seats.",
             got_cnt, taken_cnt, SEATS);
    $display("Seen %0d ignored transactions and %0d grants.", flagged_cnt, grant_cnt);
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #LIMIT_TIME;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: ring_resource_token_arbiter_core.f
+incdir+rtl
rtl/rrta_pkg.sv
rtl/rrta_in_stage.sv
rtl/rrta_step.sv
rtl/ring_resource_token_arbiter_core.sv
tb/ring_resource_token_arbiter_core_tb.sv
